// ===== rtl/mccsl_pkg.sv =====
// ----------------------------------------------------------------------------
// mccsl_pkg
// types, codes and constants shared by the control-change level converter
// ----------------------------------------------------------------------------
package mccsl_pkg;

	// request command codes
	typedef enum logic [1:0] {
		CMD_MIDI = 2'd0,
		CMD_TICK = 2'd1,
		CMD_ARM  = 2'd2,
		CMD_END  = 2'd3
	} cmd_t;

	// front end sequencer states
	typedef enum logic [1:0] {
		FS_CLEAR,
		FS_IDLE,
		FS_CC_WR,
		FS_TICK
	} fstate_t;

	localparam logic [3:0]  CC_KIND    = 4'hB;    // control change status kind
	localparam logic [7:0]  VAL_NEG_MAX = 8'h80;  // -128, clamped to -127
	localparam logic [7:0]  VAL_NEG_LIM = 8'h81;  // -127
	localparam logic [6:0]  HALF_CODE  = 7'd64;   // maps to exactly one half
	localparam int          COEF_W     = 16;
	localparam logic [15:0] COEF_RESET = 16'd41;
	localparam int          VAL_W      = 8;
	localparam int          CTRL_W     = 7;
	localparam int          QUEUE_DEPTH = 4;
	localparam int          QCNT_W     = $clog2(QUEUE_DEPTH) + 1;

	// index width for a count of n, never below one bit
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ===== rtl/mccsl_if.sv =====
// ----------------------------------------------------------------------------
// mccsl channel interfaces
// request, result and coefficient write channels with valid/ready
// ----------------------------------------------------------------------------
interface mccsl_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [7:0]        status_byte;
	logic [6:0]        controller_byte;
	logic [7:0]        value_byte;
	logic [3:0]        slot;
	logic signed [7:0] typed_controller;

	modport source (output valid, command, status_byte, controller_byte, value_byte, slot,
		typed_controller, input ready);
	modport sink (input valid, command, status_byte, controller_byte, value_byte, slot,
		typed_controller, output ready);
endinterface

interface mccsl_res_if #(parameter int LEVEL_W = 18);
	logic                      valid;
	logic                      ready;
	logic [3:0]                channel;
	logic signed [LEVEL_W-1:0] level;
	logic                      last;

	modport source (output valid, channel, level, last, input ready);
	modport sink (input valid, channel, level, last, output ready);
endinterface

interface mccsl_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] smoothing_coefficient;

	modport source (output valid, smoothing_coefficient, input ready);
	modport sink (input valid, smoothing_coefficient, output ready);
endinterface

// ===== rtl/mccsl_fifo.sv =====
// ----------------------------------------------------------------------------
// mccsl_fifo
// short queue of per-channel jobs between front end and smoothing pipeline
// ----------------------------------------------------------------------------
module mccsl_fifo import mccsl_pkg::*; #(
	parameter int W = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [W-1:0]      push_data,
	input  logic              pop,
	output logic [W-1:0]      pop_data,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	localparam int AW = idx_w(QUEUE_DEPTH);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty    = (cnt_q == '0);
	assign count    = cnt_q;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> int'(cnt_q) < QUEUE_DEPTH)
		else $error("queue written while full");

endmodule

// ===== rtl/mccsl_front.sv =====
// ----------------------------------------------------------------------------
// mccsl_front
// takes requests, keeps controller values and learning, issues tick jobs
// ----------------------------------------------------------------------------
module mccsl_front import mccsl_pkg::*; #(
	parameter int CONTROLLERS = 128,
	parameter int CHANNELS    = 16,
	parameter int SLOTS       = 16,
	parameter int E_W         = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	mccsl_req_if.sink         req,
	output logic              push,
	output logic [E_W-1:0]    push_data,
	input  logic [QCNT_W-1:0] q_count
);

	localparam int CCW  = idx_w(CONTROLLERS);
	localparam int CHW  = idx_w(CHANNELS);
	localparam int SW   = idx_w(SLOTS);
	localparam int CVAW = CCW + CHW;

	fstate_t state_q, state_d;

	logic [VAL_W-1:0]  cv_mem [2**CVAW];
	logic [VAL_W-1:0]  cv_rd_q;
	logic              cv_we, cv_re;
	logic [CVAW-1:0]   cv_wa, cv_ra;
	logic [VAL_W-1:0]  cv_wd;

	logic [CVAW-1:0]   clr_cnt_q;
	logic [CTRL_W-1:0] map_q [SLOTS];
	logic              armed_q;
	logic [SW-1:0]     lslot_q;

	logic [CCW-1:0]    cc_q;
	logic [CHW-1:0]    mch_q;
	logic [VAL_W-1:0]  val_q;

	logic [SW-1:0]     tslot_q;
	logic [CTRL_W-1:0] tcc_q;
	logic              tzero_q;
	logic [CHW-1:0]    ch_cnt_q;
	logic              pend_q;
	logic [CHW-1:0]    pend_ch_q;
	logic              pend_last_q;

	logic              acc, issue, midi_ok, slot_ok, typed_ok, end_hit;
	cmd_t              cmd;
	logic [VAL_W-1:0]  val_in;
	logic [CCW-1:0]    cc_in;
	logic [CHW-1:0]    ch_in;
	logic [SW-1:0]     slot_in;

	// request decode
	assign cmd     = cmd_t'(req.command);
	assign acc     = req.valid && req.ready;
	assign cc_in   = req.controller_byte[CCW-1:0];
	assign ch_in   = req.status_byte[CHW-1:0];
	assign slot_in = req.slot[SW-1:0];
	assign midi_ok = (req.status_byte[7:4] == CC_KIND)
		&& (int'(req.controller_byte) < CONTROLLERS)
		&& (int'(req.status_byte[3:0]) < CHANNELS);
	assign slot_ok  = int'(req.slot) < SLOTS;
	assign typed_ok = !req.typed_controller[7]
		&& (int'(req.typed_controller[6:0]) < CONTROLLERS);
	assign end_hit  = armed_q && (lslot_q == slot_in);
	assign val_in   = (req.value_byte == VAL_NEG_MAX) ? VAL_NEG_LIM : req.value_byte;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_CLEAR: begin
				if (&clr_cnt_q) state_d = FS_IDLE;
			end
			FS_IDLE: begin
				if (acc && cmd == CMD_MIDI && midi_ok) begin
					state_d = FS_CC_WR;
				end else if (acc && cmd == CMD_TICK && slot_ok) begin
					state_d = FS_TICK;
				end
			end
			FS_CC_WR: state_d = FS_IDLE;
			FS_TICK: begin
				if (issue && int'(ch_cnt_q) == CHANNELS - 1) state_d = FS_IDLE;
			end
			default: state_d = FS_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		cv_we     = 1'b0;
		cv_wa     = clr_cnt_q;
		cv_wd     = '0;
		cv_re     = 1'b0;
		cv_ra     = {cc_in, ch_in};
		issue     = 1'b0;
		case (state_q)
			FS_CLEAR: begin
				cv_we = 1'b1;
			end
			FS_IDLE: begin
				req.ready = 1'b1;
				cv_re     = req.valid && cmd == CMD_MIDI && midi_ok;
			end
			FS_CC_WR: begin
				cv_we = 1'b1;
				cv_wa = {cc_q, mch_q};
				cv_wd = val_q;
			end
			FS_TICK: begin
				issue = (int'(q_count) + int'(pend_q)) < QUEUE_DEPTH;
				cv_re = issue;
				cv_ra = {tcc_q[CCW-1:0], ch_cnt_q};
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// controller value memory
	always_ff @(posedge clk) begin
		if (cv_we) begin
			cv_mem[cv_wa] <= cv_wd;
		end
		if (cv_re) begin
			cv_rd_q <= cv_mem[cv_ra];
		end
	end

	// job to the queue in the cycle after its value read
	assign push      = pend_q;
	assign push_data = {tslot_q, pend_ch_q, (tzero_q ? {VAL_W{1'b0}} : cv_rd_q), pend_last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FS_CLEAR;
			clr_cnt_q <= '0;
			armed_q   <= 1'b0;
			lslot_q   <= '0;
			pend_q    <= 1'b0;
			ch_cnt_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				map_q[i] <= CTRL_W'(i);
			end
		end else begin
			state_q <= state_d;
			pend_q  <= issue;
			if (state_q == FS_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + CVAW'(1);
			end
			if (state_q == FS_CC_WR && armed_q && cv_rd_q != val_q) begin
				map_q[lslot_q] <= CTRL_W'(cc_q);
				armed_q        <= 1'b0;
			end
			if (acc && cmd == CMD_ARM && slot_ok) begin
				armed_q <= 1'b1;
				lslot_q <= slot_in;
			end
			if (acc && cmd == CMD_END && slot_ok && end_hit) begin
				if (typed_ok) begin
					map_q[slot_in] <= req.typed_controller[6:0];
				end
				armed_q <= 1'b0;
			end
			if (acc && cmd == CMD_TICK) begin
				ch_cnt_q <= '0;
			end else if (issue) begin
				ch_cnt_q <= ch_cnt_q + CHW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_MIDI) begin
			cc_q  <= cc_in;
			mch_q <= ch_in;
			val_q <= val_in;
		end
		if (acc && cmd == CMD_TICK) begin
			tslot_q <= slot_in;
			tcc_q   <= map_q[slot_in];
			tzero_q <= int'(map_q[slot_in]) >= CONTROLLERS;
		end
		if (issue) begin
			pend_ch_q   <= ch_cnt_q;
			pend_last_q <= int'(ch_cnt_q) == CHANNELS - 1;
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> int'(q_count) < QUEUE_DEPTH)
		else $error("job pushed into full queue");

	a_learn_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(armed_q) |-> $past(state_q) == FS_CC_WR || $past(state_q) == FS_IDLE)
		else $error("learning ended outside message or end request");

endmodule

// ===== rtl/mccsl_back.sv =====
// ----------------------------------------------------------------------------
// mccsl_back
// per slot and channel exponential smoother with result register
// ----------------------------------------------------------------------------
module mccsl_back import mccsl_pkg::*; #(
	parameter int CHANNELS  = 16,
	parameter int SLOTS     = 16,
	parameter int FRAC_BITS = 16,
	parameter int E_W       = 17
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [E_W-1:0] job,
	input  logic           job_empty,
	output logic           job_pop,
	mccsl_cfg_if.sink      cfg,
	mccsl_res_if.source    result
);

	localparam int F   = FRAC_BITS;
	localparam int LW  = F + 2;
	localparam int DW  = F + 3;
	localparam int PW  = F + COEF_W;
	localparam int CHW = idx_w(CHANNELS);
	localparam int SW  = idx_w(SLOTS);
	localparam int AW  = SW + CHW;
	localparam logic signed [DW-1:0] ONE_D = DW'(64'd1 << F);
	localparam logic [F:0]          HALF_T = (F + 1)'(64'd1 << (F - 1));

	// value to target magnitude, rounded to nearest
	logic [F:0] tgt_tab [128];
	for (genvar i = 0; i < 128; i++) begin : g_tab
		localparam logic [F:0] TV = (F + 1)'(((64'(i) << F) + 64'd63) / 64'd127);
		assign tgt_tab[i] = TV;
	end

	logic [COEF_W-1:0] coef_q;
	logic [LW-1:0]     lvl_mem [2**AW];
	logic [2**AW-1:0]  lvl_vld_q;

	logic [SW-1:0]     h_slot;
	logic [CHW-1:0]    h_ch;
	logic [VAL_W-1:0]  h_val;
	logic              h_last;
	logic [AW-1:0]     h_addr;
	logic              adv, hazard;

	logic              vld_s1, vld_s2, vld_s3;
	logic [AW-1:0]     addr_s1, addr_s2, addr_s3;
	logic [CHW-1:0]    ch_s1, ch_s2, ch_s3;
	logic              last_s1, last_s2, last_s3;
	logic [VAL_W-1:0]  val_s1;
	logic [LW-1:0]     rd_s1;
	logic              ok_s1;

	logic signed [LW-1:0] tgt_s2, cur_s2, tgt_s3, cur_s3;
	logic              dneg_s2, jump_s2, dneg_s3, jump_s3;
	logic [F-1:0]      dmag_s2;
	logic [PW-1:0]     prod_s3;

	logic              out_vld_q, out_last_q;
	logic [3:0]        out_ch_q;
	logic [LW-1:0]     out_lvl_q;

	// stage one combinational
	logic              vneg;
	logic [6:0]        vabs;
	logic [F:0]        tmag;
	logic signed [LW-1:0] tgt, cur;
	logic signed [DW-1:0] diff;
	logic [LW-1:0]     dmag;

	// final stage combinational
	logic [PW:0]       rnd;
	logic [F:0]        step;
	logic signed [DW-1:0] nxt, cur_d;
	logic [LW-1:0]     new_lvl;

	assign {h_slot, h_ch, h_val, h_last} = job;
	assign h_addr = {h_slot, h_ch};

	assign adv    = !out_vld_q || result.ready;
	assign hazard = (vld_s1 && addr_s1 == h_addr) || (vld_s2 && addr_s2 == h_addr)
		|| (vld_s3 && addr_s3 == h_addr);
	assign job_pop = adv && !job_empty && !hazard;

	assign cfg.ready = 1'b1;

	always_comb begin
		vneg = val_s1[7];
		vabs = vneg ? 7'(-val_s1) : val_s1[6:0];
		tmag = (!vneg && vabs == HALF_CODE) ? HALF_T : tgt_tab[vabs];
		tgt  = vneg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
		cur  = ok_s1 ? $signed(rd_s1) : '0;
		diff = $signed({tgt[LW-1], tgt}) - $signed({cur[LW-1], cur});
		dmag = diff[DW-1] ? LW'(-diff) : diff[LW-1:0];
	end

	always_comb begin
		rnd   = {1'b0, prod_s3} + (PW + 1)'(1 << (COEF_W - 1));
		step  = rnd[PW:COEF_W];
		cur_d = $signed({cur_s3[LW-1], cur_s3});
		nxt   = dneg_s3 ? cur_d - $signed(DW'(step)) : cur_d + $signed(DW'(step));
		if (jump_s3) begin
			new_lvl = tgt_s3;
		end else if (nxt > ONE_D) begin
			new_lvl = ONE_D[LW-1:0];
		end else if (nxt < -ONE_D) begin
			new_lvl = LW'(-ONE_D);
		end else begin
			new_lvl = nxt[LW-1:0];
		end
	end

	// level memory: read on pop, written as a result leaves the last stage
	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			lvl_mem[addr_s3] <= new_lvl;
		end
		if (job_pop) begin
			rd_s1 <= lvl_mem[h_addr];
			ok_s1 <= lvl_vld_q[h_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q    <= COEF_RESET;
			lvl_vld_q <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				coef_q <= cfg.smoothing_coefficient;
			end
			if (adv) begin
				vld_s1    <= job_pop;
				vld_s2    <= vld_s1;
				vld_s3    <= vld_s2;
				out_vld_q <= vld_s3;
				if (vld_s3) begin
					lvl_vld_q[addr_s3] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1 <= h_addr;
			ch_s1   <= h_ch;
			last_s1 <= h_last;
			val_s1  <= h_val;

			addr_s2 <= addr_s1;
			ch_s2   <= ch_s1;
			last_s2 <= last_s1;
			tgt_s2  <= tgt;
			cur_s2  <= cur;
			dneg_s2 <= diff[DW-1];
			jump_s2 <= |dmag[LW-1:F];
			dmag_s2 <= dmag[F-1:0];

			addr_s3 <= addr_s2;
			ch_s3   <= ch_s2;
			last_s3 <= last_s2;
			tgt_s3  <= tgt_s2;
			cur_s3  <= cur_s2;
			dneg_s3 <= dneg_s2;
			jump_s3 <= jump_s2;
			prod_s3 <= PW'(dmag_s2) * PW'(coef_q);

			out_ch_q   <= 4'(ch_s3);
			out_lvl_q  <= new_lvl;
			out_last_q <= last_s3;
		end
	end

	assign result.valid   = out_vld_q;
	assign result.channel = out_ch_q;
	assign result.level   = $signed(out_lvl_q);
	assign result.last    = out_last_q;

	a_no_same_slot: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 |-> addr_s1 != addr_s2)
		else $error("two jobs for one level in flight");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !job_empty)
		else $error("job taken from empty queue");

endmodule

// ===== rtl/midi_cc_to_smoothed_levels.sv =====
// ----------------------------------------------------------------------------
// midi_cc_to_smoothed_levels
// control change messages to per-channel smoothed levels in signed Q1.16
// ----------------------------------------------------------------------------
// A request is taken on req when valid and ready are both high. Control change
// messages (status kind 0xB) store their clamped signed value per controller
// and channel through a value memory read for the learn compare, then the
// write; arm and end learning are handled as they are accepted. A tick is
// accepted and then the front end reads the controller value memory once per
// channel (CHANNELS, 16 by default), pausing while the queue has no room.
// Each read becomes a job in a four-entry queue; the smoothing pipeline behind
// it emits one level per cycle while no job for the same slot and channel is
// in flight, a job passing stages s1, s2 and s3 into the result register, and
// stalls on its own when result is not ready. After reset all entries of the
// value memory, 2^(ceil log2 CONTROLLERS + ceil log2 CHANNELS) of them
// (2048 by default), are cleared, during which no request is taken;
// coefficient writes on cfg are taken at any time and should be made while the
// block is quiet.
// ----------------------------------------------------------------------------
module midi_cc_to_smoothed_levels import mccsl_pkg::*; #(
	parameter int CONTROLLERS = 128,
	parameter int CHANNELS    = 16,
	parameter int SLOTS       = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	mccsl_req_if.sink   req,
	mccsl_res_if.source result,
	mccsl_cfg_if.sink   cfg
);

	// job: slot, channel, value, last flag
	localparam int E_W = idx_w(SLOTS) + idx_w(CHANNELS) + VAL_W + 1;

	logic              push, pop, q_empty;
	logic [E_W-1:0]    push_data, pop_data;
	logic [QCNT_W-1:0] q_count;

	// front end: request decode, value table, learning, tick sequencing
	mccsl_front #(
		.CONTROLLERS (CONTROLLERS),
		.CHANNELS    (CHANNELS),
		.SLOTS       (SLOTS),
		.E_W         (E_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.q_count   (q_count)
	);

	// decoupling queue of per-channel jobs
	mccsl_fifo #(
		.W (E_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty),
		.count     (q_count)
	);

	// back end: smoothing pipeline, level store and result register
	mccsl_back #(
		.CHANNELS  (CHANNELS),
		.SLOTS     (SLOTS),
		.FRAC_BITS (FRAC_BITS),
		.E_W       (E_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (pop_data),
		.job_empty (q_empty),
		.job_pop   (pop),
		.cfg       (cfg),
		.result    (result)
	);

endmodule
